[design/lphi_pkg.sv]
`timescale 1ns / 1ps
// Package for the linear probe hash insert unit.
// Holds the default sizes, the reset table size and the controller state type.
package lphi_pkg;

	localparam int MAX_SLOTS_DEF = 256;
	localparam int TAG_BITS_DEF  = 16;
	localparam int RESET_SLOTS   = 16;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_CHECK
	} state_t;

endpackage

[design/linear_probe_hash_insert_unit.sv]
`timescale 1ns / 1ps
// Top level of the linear probe hash insert unit: hashing divider, probe
// controller and slot memory. Depends on lphi_pkg.
//
// Usage
//   Input: one character a word, taken at a rising edge with start high and busy low.
//   char_code is added to the running sum; word_end marks the last character,
//   and word_tag is stored with the word at that point.
//   Result: at each word end one word on slot_index, placed, overflow and
//   table_size, shown for exactly one cycle with done high. The receiver
//   cannot stall; it must take the word in that cycle.
//   Configuration: slot_count_we writes slot_count as the active table size
//   (0 reads as 1, above MAX_SLOTS as MAX_SLOTS); write only while idle.
// Timing
//   Every character runs a restoring remainder unit, one bit a cycle over
//   max(clog2(MAX_SLOTS), 8) + 1 bits. At a word end each probe is a memory
//   read in ST_READ, then check and write back in ST_CHECK, through the slot
//   memory; the result appears in the cycle after the final check. busy
//   drops as done rises, so the next character may be taken while the
//   result is on the ports.
// Reset
//   arst_n clears the control state, loads the table size with 16 (RESET_SLOTS,
//   capped at MAX_SLOTS) and starts a clearing pass over all MAX_SLOTS slots with busy high.
module linear_probe_hash_insert_unit
	import lphi_pkg::*;
#(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF,
	parameter int TAG_BITS  = TAG_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [7:0]                   char_code,
	input  logic                         word_end,
	input  logic [TAG_BITS-1:0]          word_tag,
	input  logic                         slot_count_we,
	input  logic [$clog2(MAX_SLOTS+1)-1:0] slot_count,
	output logic                         done,
	output logic [$clog2(MAX_SLOTS)-1:0] slot_index,
	output logic                         placed,
	output logic                         overflow,
	output logic [$clog2(MAX_SLOTS+1)-1:0] table_size
);

	localparam int IW       = $clog2(MAX_SLOTS);
	localparam int SW       = $clog2(MAX_SLOTS + 1);
	localparam int XW       = ((IW > 8) ? IW : 8) + 1;
	localparam int CW       = $clog2(XW);
	localparam int RST_SIZE = (RESET_SLOTS > MAX_SLOTS) ? MAX_SLOTS : RESET_SLOTS;

	state_t state_q, state_d;

	logic [SW-1:0]       n_q;
	logic [IW-1:0]       sum_q;
	logic [IW-1:0]       clr_addr_q;
	logic [CW-1:0]       div_cnt_q;
	logic                done_q;

	logic [XW-1:0]       x_q;
	logic [SW-1:0]       r_q;
	logic [TAG_BITS-1:0] tag_q;
	logic                end_q;
	logic [IW-1:0]       pos_q;
	logic [IW-1:0]       home_q;
	logic [TAG_BITS:0]   rd_q;

	logic [IW-1:0]       res_slot_q;
	logic                res_placed_q;
	logic                res_ovf_q;
	logic [SW-1:0]       res_size_q;

	logic [TAG_BITS:0]   mem [MAX_SLOTS];

	logic [SW:0]         rs;
	logic [SW:0]         n_ext;
	logic [SW:0]         r_next;
	logic                div_last;
	logic                clr_last;
	logic [SW-1:0]       pos_inc;
	logic [IW-1:0]       wrap_pos;
	logic                slot_free;
	logic                at_home;
	logic                can_grow;
	logic                give_up;
	logic [SW-1:0]       cfg_size;

	logic                mem_we;
	logic [IW-1:0]       mem_addr;
	logic [TAG_BITS:0]   mem_wdata;

	// Restoring remainder step, probe arithmetic and table size clamp
	always_comb begin
		rs        = {r_q, x_q[XW-1]};
		n_ext     = {1'b0, n_q};
		r_next    = (rs >= n_ext) ? (rs - n_ext) : rs;
		div_last  = (div_cnt_q == CW'(XW - 1));
		clr_last  = (clr_addr_q == IW'(MAX_SLOTS - 1));
		pos_inc   = SW'(pos_q) + SW'(1);
		wrap_pos  = (pos_inc == n_q) ? '0 : pos_inc[IW-1:0];
		slot_free = !rd_q[TAG_BITS];
		at_home   = (wrap_pos == home_q);
		can_grow  = (n_q < SW'(MAX_SLOTS));
		give_up   = !slot_free && at_home && !can_grow;
		if (slot_count == '0) begin
			cfg_size = SW'(1);
		end else if (slot_count > SW'(MAX_SLOTS)) begin
			cfg_size = SW'(MAX_SLOTS);
		end else begin
			cfg_size = slot_count;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_last) state_d = end_q ? ST_READ : ST_IDLE;
			end
			ST_READ: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = (slot_free || give_up) ? ST_IDLE : ST_READ;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = pos_q;
		mem_wdata = {1'b1, tag_q};
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_addr_q;
				mem_wdata = '0;
			end
			ST_CHECK: begin
				mem_we = slot_free;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			n_q        <= SW'(RST_SIZE);
			sum_q      <= '0;
			clr_addr_q <= '0;
			div_cnt_q  <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_CHECK) && (slot_free || give_up);
			if (state_q == ST_CLEAR) clr_addr_q <= clr_addr_q + IW'(1);
			if (state_q == ST_IDLE && start) begin
				div_cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q + CW'(1);
			end
			if (state_q == ST_DIV && div_last) sum_q <= end_q ? '0 : r_next[IW-1:0];
			// grow by one slot once the probe has come back round to home, if below MAX_SLOTS; a slot_count write wins
			if (slot_count_we) begin
				n_q <= cfg_size;
			end else if (state_q == ST_CHECK && !slot_free && at_home && can_grow) begin
				n_q <= n_q + SW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			x_q   <= XW'(sum_q) + XW'(char_code);
			r_q   <= '0;
			tag_q <= word_tag;
			end_q <= word_end;
		end
		if (state_q == ST_DIV) begin
			x_q <= x_q << 1;
			r_q <= r_next[SW-1:0];
			if (div_last) begin
				pos_q  <= r_next[IW-1:0];
				home_q <= r_next[IW-1:0];
			end
		end
		if (state_q == ST_CHECK) begin
			if (slot_free) begin
				res_slot_q   <= pos_q;
				res_placed_q <= 1'b1;
				res_ovf_q    <= 1'b0;
				res_size_q   <= n_q;
			end else if (give_up) begin
				res_slot_q   <= '0;
				res_placed_q <= 1'b0;
				res_ovf_q    <= 1'b1;
				res_size_q   <= n_q;
			end else begin
				pos_q <= wrap_pos;
			end
		end
	end

	// Slot memory: used bit above the tag, registered read
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		rd_q <= mem[pos_q];
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign slot_index = res_slot_q;
	assign placed     = res_placed_q;
	assign overflow   = res_ovf_q;
	assign table_size = res_size_q;

`ifndef NO_ASSERTIONS
	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (placed ^ overflow))
		else $error("result word is neither placed nor dropped exactly once");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overflow) |-> (table_size == SW'(MAX_SLOTS)))
		else $error("overflow reported below the maximum table size");

	a_size_range: assert property (@(posedge clk) disable iff (!arst_n)
		(n_q != '0) && (n_q <= SW'(MAX_SLOTS)))
		else $error("active table size out of range");

	a_probe_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> (SW'(pos_q) < n_q))
		else $error("probe position beyond the active table size");

	a_done_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_CHECK))
		else $error("result strobe without a preceding slot check");
`endif

endmodule
